>>> design/grt_pkg.sv
package grt_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam logic [1:0] ST_WALL  = 2'd0;
    localparam logic [1:0] ST_EXIT  = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;

    localparam logic [19:0] DIST_MAX   = 20'hFFFFF;
    localparam logic [19:0] DIST_MIN   = 20'd41;
    localparam logic [31:0] RECIP_ONE  = 32'h4000_0000;
    localparam logic [6:0]  DIM_RESET  = 7'd64;

    typedef enum logic [1:0] {
        DIV_RX,
        DIV_RY,
        DIV_DIST
    } t_div_sel;

    typedef struct packed {
        logic               cmd;
        logic [11:0]        tile_index;
        logic [7:0]         tile_value;
        logic [17:0]        pos_x;
        logic [17:0]        pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } t_in_word;

    typedef struct packed {
        logic [19:0] distance;
        logic        hit_side;
        logic [11:0] wall_frac;
        logic [3:0]  texture_index;
        logic [1:0]  status;
    } t_out_word;

    typedef struct packed {
        logic     load;
        logic     write;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_rx;
        logic     cap_ry;
        logic     init_sx;
        logic     init_sy;
        logic     step;
        logic     check;
        logic     prep;
        logic     cap_dist;
        logic     mul;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic exited;
        logic wall;
        logic limit;
    } t_sts;

endpackage

>>> design/grt_div.sv
module grt_div #(
    parameter int DW = 35
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [15:0]   i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [15:0]   r_rem;
    logic [15:0]   r_dv;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [16:0]   sh;
    logic [16:0]   diff;
    logic          qbit;

    // one quotient bit per cycle, restoring
    always_comb begin
        sh   = {r_rem, r_q[DW-1]};
        diff = sh - {1'b0, r_dv};
        qbit = (sh >= {1'b0, r_dv});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dv  <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], qbit};
            r_rem <= qbit ? diff[15:0] : sh[15:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> design/grt_dp.sv
module grt_dp #(
    parameter int MAP_SIDE      = 64,
    parameter int STEP_LIMIT    = 256,
    parameter int TEXTURE_COUNT = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  grt_pkg::t_cmd      i_cmd,
    output grt_pkg::t_sts      o_sts,
    input  grt_pkg::t_in_word  i_in_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_data,
    output grt_pkg::t_out_word o_out_word
);

    localparam int MW    = ($clog2(MAP_SIDE) + 2 > 8) ? $clog2(MAP_SIDE) + 2 : 8;
    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int DIM_W = $clog2(MAP_SIDE + 1);
    localparam int CW    = (DIM_W > 7) ? DIM_W : 7;
    localparam int NM    = ((MW + 12 > 19) ? MW + 12 : 19) + 1;
    localparam int DIV_W = NM + 14;
    localparam int SD_W  = 33 + $clog2(STEP_LIMIT);
    localparam int CNT_W = $clog2(STEP_LIMIT + 1);
    localparam logic [16:0] TEX_M = 17'((65536 + TEXTURE_COUNT - 1) / TEXTURE_COUNT);
    localparam logic [4:0]  TEX_C = 5'(TEXTURE_COUNT);

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        mag16 = v[15] ? 16'(-v) : 16'(v);
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [6:0] v);
        logic [CW-1:0] e;
        e = CW'(v);
        if (v == 7'd0) begin
            clamp_dim = DIM_W'(1);
        end else if (e > CW'(MAP_SIDE)) begin
            clamp_dim = DIM_W'(MAP_SIDE);
        end else begin
            clamp_dim = DIM_W'(e);
        end
    endfunction

    logic [7:0]            mem [DEPTH];
    logic [6:0]            r_cfg_w, r_cfg_h;
    logic [17:0]           r_px, r_py;
    logic signed [15:0]    r_dx, r_dy;
    logic [DIM_W-1:0]      r_w, r_h;
    logic [30:0]           r_ddx, r_ddy;
    logic [SD_W-1:0]       r_sdx, r_sdy;
    logic signed [MW-1:0]  r_mx, r_my;
    logic                  r_side;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_exit;
    logic [7:0]            r_tile;
    logic [NM-1:0]         r_nmag;
    logic [15:0]           r_dmag;
    logic                  r_dz, r_np;
    logic [19:0]           r_dist;
    logic signed [36:0]    r_prod;
    grt_pkg::t_out_word    r_out;

    logic [DIV_W-1:0]      dv_dividend;
    logic [15:0]           dv_divisor;
    logic                  dv_done;
    logic [DIV_W-1:0]      dv_quot;

    logic [31:0]           wr_idx;
    logic                  wr_ok;
    logic [12:0]           frx, fry;
    logic [43:0]           sx_prod, sy_prod;
    logic                  x_go;
    logic signed [MW-1:0]  stx, sty, w_s, h_s;
    logic                  out_map;
    logic [2*MW-1:0]       addr_full;
    logic signed [MW-1:0]  cell_m;
    logic signed [NM:0]    cell_e, pos_e, num;
    logic signed [15:0]    d_sel;
    logic [19:0]           q_sat, d_raw;
    logic signed [15:0]    m_fac;
    logic signed [36:0]    scaled;
    logic [11:0]           base_lo;
    logic [7:0]            vm1;
    logic [24:0]           tp;
    logic [12:0]           tqt;
    logic [7:0]            trem;
    logic [3:0]            tex;
    logic [1:0]            st;

    grt_div #(.DW(DIV_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dv_dividend),
        .i_divisor  (dv_divisor),
        .o_done     (dv_done),
        .o_quot     (dv_quot)
    );

    always_comb begin
        unique case (i_cmd.div_sel)
            grt_pkg::DIV_RX: begin
                dv_dividend = DIV_W'(grt_pkg::RECIP_ONE);
                dv_divisor  = mag16(r_dx);
            end
            grt_pkg::DIV_RY: begin
                dv_dividend = DIV_W'(grt_pkg::RECIP_ONE);
                dv_divisor  = mag16(r_dy);
            end
            grt_pkg::DIV_DIST: begin
                dv_dividend = {r_nmag, 14'b0};
                dv_divisor  = r_dmag;
            end
            default: begin
                dv_dividend = {r_nmag, 14'b0};
                dv_divisor  = r_dmag;
            end
        endcase
    end

    always_comb begin
        wr_idx  = 32'(i_in_word.tile_index);
        wr_ok   = wr_idx < 32'(DEPTH);
        frx     = r_dx[15] ? {1'b0, r_px[11:0]} : 13'd4096 - {1'b0, r_px[11:0]};
        fry     = r_dy[15] ? {1'b0, r_py[11:0]} : 13'd4096 - {1'b0, r_py[11:0]};
        sx_prod = {31'b0, frx} * {13'b0, r_ddx};
        sy_prod = {31'b0, fry} * {13'b0, r_ddy};
        x_go    = (r_dx != 16'sd0) && ((r_dy == 16'sd0) || (r_sdx < r_sdy));
        stx     = r_dx[15] ? {MW{1'b1}} : MW'(1);
        sty     = r_dy[15] ? {MW{1'b1}} : MW'(1);
        w_s     = signed'(MW'(r_w));
        h_s     = signed'(MW'(r_h));
        out_map = (r_mx < 0) || (r_my < 0) || (r_mx >= w_s) || (r_my >= h_s);
        addr_full = ({{MW{1'b0}}, r_my} * {{MW{1'b0}}, MW'(r_w)}) + {{MW{1'b0}}, r_mx};

        cell_m = r_side ? r_my : r_mx;
        cell_e = (NM + 1)'(cell_m);
        pos_e  = signed'((NM + 1)'(r_side ? r_py : r_px));
        num    = (cell_e <<< 12) - pos_e
               + ((r_side ? r_dy[15] : r_dx[15]) ? (NM + 1)'(4096) : (NM + 1)'(0));
        d_sel  = r_side ? r_dy : r_dx;

        q_sat  = (dv_quot > DIV_W'(grt_pkg::DIST_MAX)) ? grt_pkg::DIST_MAX : dv_quot[19:0];
        d_raw  = r_dz ? grt_pkg::DIST_MAX : (r_np ? 20'd0 : q_sat);
        m_fac  = r_side ? r_dx : r_dy;

        scaled  = r_prod >>> 14;
        base_lo = r_side ? r_px[11:0] : r_py[11:0];

        vm1  = r_tile - 8'd1;
        tp   = {17'b0, vm1} * {8'b0, TEX_M};
        tqt  = {5'b0, tp[23:16]} * {8'b0, TEX_C};
        trem = vm1 - tqt[7:0];
        tex  = (!r_exit && r_tile != 8'd0) ? trem[3:0] : 4'd0;
        st   = r_exit ? grt_pkg::ST_EXIT
             : ((r_tile != 8'd0) ? grt_pkg::ST_WALL : grt_pkg::ST_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= grt_pkg::DIM_RESET;
            r_cfg_h <= grt_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == grt_pkg::REG_MAP_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end else begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_ok) begin
            mem[wr_idx[AW-1:0]] <= i_in_word.tile_value;
        end
        if (i_cmd.check) begin
            r_tile <= mem[addr_full[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= i_in_word.pos_x;
            r_py   <= i_in_word.pos_y;
            r_dx   <= i_in_word.dir_x;
            r_dy   <= i_in_word.dir_y;
            r_w    <= clamp_dim(r_cfg_w);
            r_h    <= clamp_dim(r_cfg_h);
            r_mx   <= MW'(i_in_word.pos_x[17:12]);
            r_my   <= MW'(i_in_word.pos_y[17:12]);
            r_side <= 1'b0;
            r_cnt  <= '0;
            r_exit <= 1'b0;
        end
        if (i_cmd.cap_rx) r_ddx <= (r_dx == 16'sd0) ? 31'd0 : dv_quot[30:0];
        if (i_cmd.cap_ry) r_ddy <= (r_dy == 16'sd0) ? 31'd0 : dv_quot[30:0];
        if (i_cmd.init_sx) r_sdx <= SD_W'(sx_prod[43:12]);
        if (i_cmd.init_sy) r_sdy <= SD_W'(sy_prod[43:12]);
        if (i_cmd.step) begin
            r_cnt <= r_cnt + 1'b1;
            if (x_go) begin
                r_sdx  <= r_sdx + SD_W'(r_ddx);
                r_mx   <= r_mx + stx;
                r_side <= 1'b0;
            end else begin
                r_sdy  <= r_sdy + SD_W'(r_ddy);
                r_my   <= r_my + sty;
                r_side <= 1'b1;
            end
        end
        if (i_cmd.check) r_exit <= out_map;
        if (i_cmd.prep) begin
            r_nmag <= num[NM] ? NM'(-num) : NM'(num);
            r_dmag <= mag16(d_sel);
            r_dz   <= d_sel == 16'sd0;
            r_np   <= (num == '0) || (num[NM] != d_sel[15]);
        end
        if (i_cmd.cap_dist) r_dist <= (d_raw < grt_pkg::DIST_MIN) ? grt_pkg::DIST_MIN : d_raw;
        if (i_cmd.mul) r_prod <= $signed({1'b0, r_dist}) * m_fac;
        if (i_cmd.out_load) begin
            r_out.distance      <= r_dist;
            r_out.hit_side      <= r_side;
            r_out.wall_frac     <= base_lo + scaled[11:0];
            r_out.texture_index <= tex;
            r_out.status        <= st;
        end
    end

    assign o_sts.div_done = dv_done;
    assign o_sts.exited   = r_exit;
    assign o_sts.wall     = r_tile != 8'd0;
    assign o_sts.limit    = r_cnt == CNT_W'(STEP_LIMIT);
    assign o_out_word     = r_out;

endmodule

>>> design/grt_ctrl.sv
module grt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_cast,
    input  logic          i_out_stall,
    input  grt_pkg::t_sts i_sts,
    output grt_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RX_GO,
        S_RX_WAIT,
        S_RY_GO,
        S_RY_WAIT,
        S_SX,
        S_SY,
        S_STEP,
        S_CHECK,
        S_TEST,
        S_PREP,
        S_DV_GO,
        S_DV_WAIT,
        S_MUL,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd           = '0;
        o_cmd.div_sel   = grt_pkg::DIV_DIST;
        o_cmd.load      = accept && (i_cast == grt_pkg::CMD_CAST);
        o_cmd.write     = accept && (i_cast == grt_pkg::CMD_WRITE);
        unique case (r_state)
            S_RX_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = grt_pkg::DIV_RX;
            end
            S_RX_WAIT: o_cmd.cap_rx = i_sts.div_done;
            S_RY_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = grt_pkg::DIV_RY;
            end
            S_RY_WAIT: o_cmd.cap_ry   = i_sts.div_done;
            S_SX:      o_cmd.init_sx  = 1'b1;
            S_SY:      o_cmd.init_sy  = 1'b1;
            S_STEP:    o_cmd.step     = 1'b1;
            S_CHECK:   o_cmd.check    = 1'b1;
            S_PREP:    o_cmd.prep     = 1'b1;
            S_DV_GO:   o_cmd.div_start = 1'b1;
            S_DV_WAIT: o_cmd.cap_dist = i_sts.div_done;
            S_MUL:     o_cmd.mul      = 1'b1;
            S_OUT:     o_cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE:    if (o_cmd.load) r_state <= S_RX_GO;
                S_RX_GO:   r_state <= S_RX_WAIT;
                S_RX_WAIT: if (i_sts.div_done) r_state <= S_RY_GO;
                S_RY_GO:   r_state <= S_RY_WAIT;
                S_RY_WAIT: if (i_sts.div_done) r_state <= S_SX;
                S_SX:      r_state <= S_SY;
                S_SY:      r_state <= S_STEP;
                S_STEP:    r_state <= S_CHECK;
                S_CHECK:   r_state <= S_TEST;
                S_TEST: begin
                    priority if (i_sts.exited || i_sts.wall || i_sts.limit) begin
                        r_state <= S_PREP;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_PREP:    r_state <= S_DV_GO;
                S_DV_GO:   r_state <= S_DV_WAIT;
                S_DV_WAIT: if (i_sts.div_done) r_state <= S_MUL;
                S_MUL:     r_state <= S_OUT;
                S_OUT:     if (out_free) r_state <= S_IDLE;
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

>>> design/grid_ray_traversal_dda.sv
// Channel | Direction | Handshake               | Word
// input   | in        | i_in_valid / o_in_stall | i_in_word  (t_in_word)
// output  | out       | o_out_valid/ i_out_stall| o_out_word (t_out_word)
// config  | in        | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// A cast runs the serial divider, D bits wide (35 at the default map side),
// one bit a cycle, for both reciprocals and the final distance, and the
// step/check/test loop once for each cell step walked. Reset is synchronous
// and active low; it clears the controller and sets both map dimensions to
// 64. The tile store has no reset. A stalled output word holds, and the next
// input word is taken while it waits.
module grid_ray_traversal_dda #(
    parameter int MAP_SIDE      = 64,
    parameter int STEP_LIMIT    = 256,
    parameter int TEXTURE_COUNT = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  grt_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output grt_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_data
);

    grt_pkg::t_cmd cmd;
    grt_pkg::t_sts sts;

    // the user must write configuration only while idle (not enforced here), so always take it
    assign o_cfg_ready = 1'b1;

    // sequence tile writes and the cast: reciprocals, side distances, walk, distance, result
    grt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cast      (i_in_word.cmd),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // hold the tile store, walk registers, shared divider and result word
    grt_dp #(
        .MAP_SIDE      (MAP_SIDE),
        .STEP_LIMIT    (STEP_LIMIT),
        .TEXTURE_COUNT (TEXTURE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_word  (o_out_word)
    );

endmodule

>>> design/grt_chk.sv
module grt_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input grt_pkg::t_out_word o_out_word
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("stalled output word changed");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status == grt_pkg::ST_WALL
                      || o_out_word.status == grt_pkg::ST_EXIT
                      || o_out_word.status == grt_pkg::ST_LIMIT))
        else $error("bad status code");

    a_dist_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.distance >= grt_pkg::DIST_MIN)
        else $error("distance below floor");

    a_exit_tex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == grt_pkg::ST_EXIT
            |-> o_out_word.texture_index == 4'd0)
        else $error("texture set on map exit");

endmodule

bind grid_ray_traversal_dda grt_chk u_grt_chk (.*);
